/* sv/iprt_pkg.sv */
// ----------------------------------------------------------------------------
// iprt_pkg: shared types and constants of the ipv4 prefix rule table
// Field widths, operation and status codes, the entry layout, the controller
// command group and the mask and key helper functions.
// ----------------------------------------------------------------------------
package iprt_pkg;

  // default table depth
  localparam int unsigned ENTRIES_DEF = 32;

  // field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned NET_W  = 32;
  localparam int unsigned PLEN_W = 6;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  // longest legal prefix and the all-ones mask
  localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(32);
  localparam logic [NET_W-1:0]  FULL_MASK  = 32'hffff_ffff;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_PREFIX = 2'd3
  } status_e;

  // one stored rule
  typedef struct packed {
    logic [NET_W-1:0]  net;
    logic [PLEN_W-1:0] plen;
    logic [ACT_W-1:0]  act;
  } entry_t;

  localparam int unsigned ENTRY_W = NET_W + PLEN_W + ACT_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request, reset the scan results
    logic rd_en;    // read the entry at the scan address
    logic cmp_en;   // read data of the compare index is present
    logic commit;   // apply the update and load the response register
  } cmd_t;

  // network mask of a prefix length, zero for prefix zero
  function automatic logic [NET_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] sh;
    sh = MAX_PREFIX - plen;
    if (plen == '0) begin
      return '0;
    end
    return FULL_MASK << sh;
  endfunction

  // true when key (na, pa) sorts below key (nb, pb): network first, then mask
  function automatic logic key_less(input logic [NET_W-1:0]  na,
                                    input logic [PLEN_W-1:0] pa,
                                    input logic [NET_W-1:0]  nb,
                                    input logic [PLEN_W-1:0] pb);
    if (na != nb) begin
      return na < nb;
    end
    return pa < pb;
  endfunction

endpackage

/* sv/iprt_req_if.sv */
// ----------------------------------------------------------------------------
// iprt_req_if: request channel of the prefix rule table
// Valid/ready handshake with opcode, address, prefix length and action.
// ----------------------------------------------------------------------------
interface iprt_req_if;
  import iprt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NET_W-1:0]  address;
  logic [PLEN_W-1:0] prefix_len;
  logic [ACT_W-1:0]  action;

  modport source (output valid, output opcode, output address, output prefix_len,
                  output action, input ready);
  modport sink (input valid, input opcode, input address, input prefix_len,
                input action, output ready);
endinterface

/* sv/iprt_rsp_if.sv */
// ----------------------------------------------------------------------------
// iprt_rsp_if: response channel of the prefix rule table
// Valid/ready handshake with result action, hit flag and status.
// ----------------------------------------------------------------------------
interface iprt_rsp_if;
  import iprt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  result_action;
  logic              hit;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result_action, output hit, output status,
                  input ready);
  modport sink (input valid, input result_action, input hit, input status,
                output ready);
endinterface

/* sv/iprt_ram.sv */
// ----------------------------------------------------------------------------
// iprt_ram: generic single-write, single-read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/iprt_ctrl.sv */
// ----------------------------------------------------------------------------
// iprt_ctrl: sequencer of the prefix rule table
// Accepts a request, walks the scan address over every slot, drains the
// read pipeline and commits once the response register is free.
// ----------------------------------------------------------------------------
module iprt_ctrl #(
  parameter int unsigned ENTRIES = iprt_pkg::ENTRIES_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       out_free_i,
  output iprt_pkg::cmd_t                             cmd_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] cmp_idx_o
);
  import iprt_pkg::*;

  localparam int unsigned IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  cmd_t             cmd;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd         = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          cnt_d       = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd.cmp_en = cmp_vld_q;
  end

  // state, scan counter and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmd.rd_en;
      cmp_idx_q <= cnt_q;
    end
  end

  assign cmd_o     = cmd;
  assign rd_addr_o = cnt_q;
  assign cmp_idx_o = cmp_idx_q;

endmodule

/* sv/iprt_dp.sv */
// ----------------------------------------------------------------------------
// iprt_dp: datapath of the prefix rule table
// Request registers, entry ram, valid bits, per-slot compare with running
// best/same/free results, update logic and the response register.
// ----------------------------------------------------------------------------
module iprt_dp #(
  parameter int unsigned ENTRIES = iprt_pkg::ENTRIES_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [iprt_pkg::ACT_W-1:0]                 cfg_data_i,
  input  logic [iprt_pkg::OP_W-1:0]                  opcode_i,
  input  logic [iprt_pkg::NET_W-1:0]                 address_i,
  input  logic [iprt_pkg::PLEN_W-1:0]                prefix_len_i,
  input  logic [iprt_pkg::ACT_W-1:0]                 action_i,
  input  iprt_pkg::cmd_t                             cmd_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] cmp_idx_i,
  output logic                                       out_free_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [iprt_pkg::ACT_W-1:0]                 result_action_o,
  output logic                                       hit_o,
  output logic [iprt_pkg::STAT_W-1:0]                status_o
);
  import iprt_pkg::*;

  localparam int unsigned IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  // request and configuration registers
  logic [ACT_W-1:0]  dflt_q;
  op_e               op_q;
  logic [NET_W-1:0]  addr_q;
  logic [NET_W-1:0]  net_q;
  logic [PLEN_W-1:0] plen_q;
  logic [ACT_W-1:0]  act_q;

  // scan results
  logic              found_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [NET_W-1:0]  best_net_q;
  logic [PLEN_W-1:0] best_plen_q;
  logic [ACT_W-1:0]  best_act_q;
  logic              same_found_q;
  logic [IDX_W-1:0]  same_idx_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  free_idx_q;

  logic [ENTRIES-1:0] valid_q;

  // response register
  logic              out_valid_q;
  logic [ACT_W-1:0]  res_act_q;
  logic              res_hit_q;
  logic [STAT_W-1:0] res_status_q;

  // ram ports
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;

  // compare terms
  logic              cmp_valid;
  logic [NET_W-1:0]  cmp_mask;
  logic              cmp_match;
  logic              cmp_better;
  logic              cmp_same;

  // update terms
  logic              upd_we;
  logic              upd_set;
  logic              upd_clr;
  logic              upd_clr_all;
  logic [IDX_W-1:0]  upd_idx;
  logic [ACT_W-1:0]  res_act;
  logic              res_hit;
  status_e           res_status;

  iprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // compare of the entry read in the previous cycle
  always_comb begin
    rd_entry   = entry_t'(ram_rdata);
    cmp_valid  = valid_q[cmp_idx_i];
    cmp_mask   = mask_of(rd_entry.plen);
    cmp_match  = cmp_valid && ((rd_entry.net & cmp_mask) == (addr_q & cmp_mask));
    cmp_better = !found_q ||
                 key_less(rd_entry.net, rd_entry.plen, best_net_q, best_plen_q);
    cmp_same   = cmp_valid && (rd_entry.net == net_q) && (rd_entry.plen == plen_q);
  end

  // update and response of the finished scan
  always_comb begin
    upd_we      = 1'b0;
    upd_set     = 1'b0;
    upd_clr     = 1'b0;
    upd_clr_all = 1'b0;
    upd_idx     = best_idx_q;
    res_act     = '0;
    res_hit     = 1'b0;
    res_status  = ST_OK;
    case (op_q)
      OP_INSERT: begin
        if (plen_q > MAX_PREFIX) begin
          res_status = ST_BAD_PREFIX;
        end else if (same_found_q) begin
          upd_we  = 1'b1;
          upd_idx = same_idx_q;
        end else if (free_found_q) begin
          upd_we  = 1'b1;
          upd_set = 1'b1;
          upd_idx = free_idx_q;
        end else begin
          res_status = ST_TABLE_FULL;
        end
      end
      OP_FIND: begin
        res_hit = found_q;
        res_act = found_q ? best_act_q : dflt_q;
      end
      OP_REMOVE: begin
        if (found_q) begin
          upd_clr = 1'b1;
          res_hit = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        upd_clr_all = 1'b1;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign ram_we        = cmd_i.commit && upd_we;
  assign ram_waddr     = upd_idx;
  assign wr_entry.net  = net_q;
  assign wr_entry.plen = plen_q;
  assign wr_entry.act  = act_q;

  // default action register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      dflt_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      addr_q <= address_i;
      net_q  <= address_i & mask_of(prefix_len_i);
      plen_q <= prefix_len_i;
      act_q  <= action_i;
    end
  end

  // scan flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      same_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      found_q      <= 1'b0;
      same_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      if (cmp_match && cmp_better) begin
        found_q <= 1'b1;
      end
      if (cmp_same) begin
        same_found_q <= 1'b1;
      end
      if (!cmp_valid) begin
        free_found_q <= 1'b1;
      end
    end
  end

  // scan payload: best match, first same key, first free slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      if (cmp_match && cmp_better) begin
        best_idx_q  <= cmp_idx_i;
        best_net_q  <= rd_entry.net;
        best_plen_q <= rd_entry.plen;
        best_act_q  <= rd_entry.act;
      end
      if (cmp_same && !same_found_q) begin
        same_idx_q <= cmp_idx_i;
      end
      if (!cmp_valid && !free_found_q) begin
        free_idx_q <= cmp_idx_i;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (upd_clr_all) begin
        valid_q <= '0;
      end else if (upd_set) begin
        valid_q[upd_idx] <= 1'b1;
      end else if (upd_clr) begin
        valid_q[upd_idx] <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_act_q    <= res_act;
      res_hit_q    <= res_hit;
      res_status_q <= res_status;
    end
  end

  assign out_free_o      = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign result_action_o = res_act_q;
  assign hit_o           = res_hit_q;
  assign status_o        = res_status_q;

endmodule

/* sv/ipv4_prefix_rule_table.sv */
// Each request walks the scan over every slot through the single read port of
// the entry ram, drains the read pipeline and commits once the response register
// is free, so requests are handled one at a time.
// A finished response waits in its own register; the next request is taken
// as soon as the commit is done. Reset empties the table at once (valid bits
// in flops) and sets the default action to 0; the entry ram is not cleared.
// ----------------------------------------------------------------------------
// ipv4_prefix_rule_table: ipv4 prefix rule table, top level
// Insert, find, remove and clear of prefix rules with a sequential scan.
// ----------------------------------------------------------------------------
module ipv4_prefix_rule_table #(
  parameter int unsigned ENTRIES = iprt_pkg::ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [iprt_pkg::ACT_W-1:0] cfg_data_i,
  iprt_req_if.sink                  req_i,
  iprt_rsp_if.source                rsp_o
);
  import iprt_pkg::*;

  localparam int unsigned IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  cmd_t             cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cmp_idx;
  logic             out_free;
  logic             in_ready;
  logic             out_valid;
  logic [ACT_W-1:0] res_act;
  logic             res_hit;
  logic [STAT_W-1:0] res_status;

  // sequencer
  iprt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .cmp_idx_o  (cmp_idx)
  );

  // datapath
  iprt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (req_i.opcode),
    .address_i       (req_i.address),
    .prefix_len_i    (req_i.prefix_len),
    .action_i        (req_i.action),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .cmp_idx_i       (cmp_idx),
    .out_free_o      (out_free),
    .out_valid_o     (out_valid),
    .out_ready_i     (rsp_o.ready),
    .result_action_o (res_act),
    .hit_o           (res_hit),
    .status_o        (res_status)
  );

  // channel hookup
  assign req_i.ready         = in_ready;
  assign rsp_o.valid         = out_valid;
  assign rsp_o.result_action = res_act;
  assign rsp_o.hit           = res_hit;
  assign rsp_o.status        = res_status;

endmodule

/* dv/ipv4_prefix_rule_table_test.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_rule_table_test: self-checking bench for the prefix rule table
// Drives insert, find, remove and clear requests through a short directed
// script and then several random phases with different operation mixes and
// default actions. Every response is checked against a behavioral model of
// the table kept in the bench or against a hand-written answer of the script,
// with random stalls on both channels.
module ipv4_prefix_rule_table_test;
  import iprt_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned LATENCY     = ENTRIES + 3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          POOL_SIZE   = 16;

  // request fields of one transfer
  typedef struct packed {
    op_e               op;
    logic [NET_W-1:0]  addr;
    logic [PLEN_W-1:0] plen;
    logic [ACT_W-1:0]  act;
  } rule_req_t;

  // response fields of one transfer
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             hit;
    status_e          status;
  } rule_answer_t;

  // one line of the directed script, with an optional hand-written answer
  typedef struct packed {
    rule_req_t    req;
    logic         typed;
    rule_answer_t ans;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [ACT_W-1:0] cfg_data_i;

  iprt_req_if req_if();
  iprt_rsp_if rsp_if();

  ipv4_prefix_rule_table #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // mirror of the rule table
  logic              tbl_used [ENTRIES];
  logic [NET_W-1:0]  tbl_net  [ENTRIES];
  logic [PLEN_W-1:0] tbl_plen [ENTRIES];
  logic [ACT_W-1:0]  tbl_act  [ENTRIES];
  logic [ACT_W-1:0]  dflt_act;

  rule_answer_t answer_q[$];
  script_row_t  script[$];
  logic [NET_W-1:0] addr_pool [POOL_SIZE];

  int err_cnt = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  rule_answer_t want_ans;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // network mask, top plen bits set
  function automatic logic [NET_W-1:0] cover_mask(logic [PLEN_W-1:0] plen);
    return ~(32'hffff_ffff >> plen);
  endfunction

  // apply one request to the mirror and return the response it should give
  function automatic rule_answer_t rule_table_apply(rule_req_t r);
    rule_answer_t ans;
    logic [NET_W-1:0] net;
    logic [NET_W-1:0] m;
    int same;
    int slot;
    int best;
    ans = '{act: '0, hit: 1'b0, status: ST_OK};
    // smallest covering key, network first then prefix length
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      m = cover_mask(tbl_plen[i]);
      if (tbl_used[i] && ((tbl_net[i] & m) == (r.addr & m))) begin
        if (best < 0 || tbl_net[i] < tbl_net[best] ||
            (tbl_net[i] == tbl_net[best] && tbl_plen[i] < tbl_plen[best])) begin
          best = i;
        end
      end
    end
    case (r.op)
      OP_INSERT: begin
        if (r.plen > 6'd32) begin
          ans.status = ST_BAD_PREFIX;
        end else begin
          net = r.addr & cover_mask(r.plen);
          same = -1;
          slot = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_used[i]) begin
              if (same < 0 && tbl_net[i] == net && tbl_plen[i] == r.plen) same = i;
            end else if (slot < 0) begin
              slot = i;
            end
          end
          if (same >= 0) begin
            tbl_act[same] = r.act;
          end else if (slot >= 0) begin
            tbl_used[slot] = 1'b1;
            tbl_net[slot]  = net;
            tbl_plen[slot] = r.plen;
            tbl_act[slot]  = r.act;
          end else begin
            ans.status = ST_TABLE_FULL;
          end
        end
      end
      OP_FIND: begin
        if (best >= 0) begin
          ans.act = tbl_act[best];
          ans.hit = 1'b1;
        end else begin
          ans.act = dflt_act;
        end
      end
      OP_REMOVE: begin
        if (best >= 0) begin
          tbl_used[best] = 1'b0;
          ans.hit = 1'b1;
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
      end
    endcase
    return ans;
  endfunction

  task automatic flag_mismatch(string what, int exp_v, int got_v);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch on %s: expected %0d, actual %0d", what, exp_v, got_v);
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (answer_q.size() == 0) begin
        flag_mismatch("unexpected response status", -1, rsp_if.status);
      end else begin
        want_ans = answer_q.pop_front();
        if (rsp_if.result_action !== want_ans.act)
          flag_mismatch("result_action", want_ans.act, rsp_if.result_action);
        if (rsp_if.hit !== want_ans.hit)
          flag_mismatch("hit", want_ans.hit, rsp_if.hit);
        if (rsp_if.status !== want_ans.status)
          flag_mismatch("status", want_ans.status, rsp_if.status);
      end
    end
  end

  // response ready: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_go && !hold_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // present one request and hold it until the transfer; valid stays high
  task automatic offer(rule_req_t r, logic typed, rule_answer_t hand_ans);
    rule_answer_t got;
    req_if.valid      <= 1'b1;
    req_if.opcode     <= r.op;
    req_if.address    <= r.addr;
    req_if.prefix_len <= r.plen;
    req_if.action     <= r.act;
    do @(posedge clk_i); while (!req_if.ready);
    got = rule_table_apply(r);
    answer_q.push_back(typed ? hand_ans : got);
  endtask

  // random request gap
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain();
    req_if.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_default_action(logic [ACT_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_act = v;
  endtask

  task automatic add_row(op_e op, logic [NET_W-1:0] a, logic [PLEN_W-1:0] p,
                         logic [ACT_W-1:0] act, logic typed, logic [ACT_W-1:0] e_act,
                         logic e_hit, status_e e_st);
    script_row_t row;
    row.req   = '{op: op, addr: a, plen: p, act: act};
    row.typed = typed;
    row.ans   = '{act: e_act, hit: e_hit, status: e_st};
    script.push_back(row);
  endtask

  // random request; mix 0 fills the table, 1 is balanced, 2 drains it
  function automatic rule_req_t draw_request(int mix);
    rule_req_t r;
    int roll;
    int th_ins;
    int th_find;
    int th_rem;
    int spread;
    case (mix)
      0:       begin th_ins = 700; th_find = 920; th_rem = 995; end
      1:       begin th_ins = 380; th_find = 750; th_rem = 970; end
      default: begin th_ins = 250; th_find = 550; th_rem = 990; end
    endcase
    roll = $urandom_range(0, 999);
    if (roll < th_ins) r.op = OP_INSERT;
    else if (roll < th_find) r.op = OP_FIND;
    else if (roll < th_rem) r.op = OP_REMOVE;
    else r.op = OP_CLEAR;
    // mostly near a pooled network so that finds and removes hit
    if ($urandom_range(0, 9) == 0) begin
      r.addr = $urandom;
    end else begin
      spread = $urandom_range(0, 32);
      r.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^
               ($urandom & ~cover_mask(PLEN_W'(spread)));
    end
    case ($urandom_range(0, 9))
      0:       r.plen = '0;
      1:       r.plen = PLEN_W'(32);
      2:       r.plen = PLEN_W'($urandom_range(33, 63));
      3, 4, 5: r.plen = PLEN_W'(8 * $urandom_range(1, 3));
      default: r.plen = PLEN_W'($urandom_range(0, 32));
    endcase
    r.act = ACT_W'($urandom_range(0, 7));
    return r;
  endfunction

  task automatic run_random(int n, int mix);
    rule_answer_t none;
    none = '{act: '0, hit: 1'b0, status: ST_OK};
    repeat (n) begin
      sender_gap();
      offer(draw_request(mix), 1'b0, none);
    end
  endtask

  // main sequence
  initial begin
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_FIND;
    req_if.address    <= '0;
    req_if.prefix_len <= '0;
    req_if.action     <= '0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= '0;
    dflt_act = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_net[i]  = '0;
      tbl_plen[i] = '0;
      tbl_act[i]  = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script, default action still at its reset value
    add_row(OP_FIND,   32'h0a00_0001, 6'd0,  3'd0, 1, 3'd0, 0, ST_OK);
    add_row(OP_REMOVE, 32'h0a00_0001, 6'd0,  3'd0, 1, 3'd0, 0, ST_NOT_FOUND);
    add_row(OP_INSERT, 32'hc0a8_0101, 6'd33, 3'd2, 1, 3'd0, 0, ST_BAD_PREFIX);
    add_row(OP_INSERT, 32'hffff_ffff, 6'd63, 3'd7, 1, 3'd0, 0, ST_BAD_PREFIX);
    add_row(OP_INSERT, 32'h0a01_0203, 6'd8,  3'd1, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0ac8_0001, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_INSERT, 32'h0a01_0203, 6'd16, 3'd2, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0a01_0909, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    // prefix zero covers every address
    add_row(OP_INSERT, 32'hffff_ffff, 6'd0,  3'd3, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'hc0a8_0001, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0a01_0000, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    // all-ones action code on a host rule
    add_row(OP_INSERT, 32'hffff_ffff, 6'd32, 3'd7, 1, 3'd0, 0, ST_OK);
    add_row(OP_REMOVE, 32'hffff_ffff, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'hffff_ffff, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    // same key again overwrites the action
    add_row(OP_INSERT, 32'h0a09_0909, 6'd8,  3'd5, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0a32_0000, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_INSERT, 32'h0000_0000, 6'd32, 3'd4, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0000_0000, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_REMOVE, 32'h0a01_0203, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_REMOVE, 32'h0a01_0203, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);
    add_row(OP_CLEAR,  32'h1234_5678, 6'd17, 3'd6, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h0a01_0203, 6'd0,  3'd0, 1, 3'd0, 0, ST_OK);
    add_row(OP_INSERT, 32'h8000_0001, 6'd31, 3'd6, 1, 3'd0, 0, ST_OK);
    add_row(OP_FIND,   32'h8000_0000, 6'd0,  3'd0, 0, 3'd0, 0, ST_OK);

    foreach (script[i]) begin
      sender_gap();
      offer(script[i].req, script[i].typed, script[i].ans);
    end

    // fill the table past full, all-ones default
    drain();
    set_default_action(3'd7);
    run_random(400, 0);

    // balanced mix, response side held off while requests keep coming
    drain();
    set_default_action(3'd0);
    hold_go = 1'b1;
    run_random(400, 1);

    // remove-heavy mix
    drain();
    set_default_action(3'd4);
    run_random(400, 2);

    // back to back, no stalls on either side
    drain();
    set_default_action(ACT_W'($urandom_range(0, 7)));
    calm = 1'b1;
    run_random(300, 1);

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/iprt_pkg.sv
sv/iprt_req_if.sv
sv/iprt_rsp_if.sv
sv/iprt_ram.sv
sv/iprt_ctrl.sv
sv/iprt_dp.sv
sv/ipv4_prefix_rule_table.sv
dv/ipv4_prefix_rule_table_test.sv
